// ===== design/tat_pkg.sv =====
package tat_pkg;

    localparam int RES_W     = 28;
    localparam int TEMP_W    = 16;
    localparam int SAMPLE_W  = 12;
    localparam int SERIES_W  = 16;
    localparam int EIU_W     = 8;
    localparam int IDX_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = SERIES_W + RES_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES  = 1'b1;

    localparam logic [EIU_W-1:0]    EIU_RESET    = 8'd73;
    localparam logic [SERIES_W-1:0] SERIES_RESET = 16'd10000;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_INTERP  = 2'd0;
    localparam status_t STATUS_FIRST   = 2'd1;
    localparam status_t STATUS_LAST    = 2'd2;
    localparam status_t STATUS_WRITTEN = 2'd3;

    localparam logic REQ_LOAD = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_R,
        ST_DIV_R,
        ST_ISSUE,
        ST_SRCH,
        ST_MUL_T,
        ST_DIV_T,
        ST_DONE
    } state_t;

endpackage

// ===== design/thermistor_adc_to_temperature_core.sv =====
// A load goes straight to completion. A conversion multiplies and divides for R, issues the
// table read, searches k = 1..entries_in_use entries and, when interpolated, multiplies and
// divides again (44-step divisions on one shared divider); a clamped result skips that second
// pair and a zero or full-scale sample also skips the first. One item is in flight; the next
// input can be taken in the cycle out_valid rises; a stalled output holds the block in ST_DONE.
// rst_n (async, active low) clears control state, presets eiu/series; table undefined.
module thermistor_adc_to_temperature_core #(
    parameter int TABLE_DEPTH    = 128,
    parameter int ADC_FULL_SCALE = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [tat_pkg::IDX_W-1:0]           entry_index,
    input  logic [tat_pkg::RES_W-1:0]           entry_resistance,
    input  logic signed [tat_pkg::TEMP_W-1:0]   entry_temperature,
    input  logic [tat_pkg::SAMPLE_W-1:0]        adc_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tat_pkg::TEMP_W-1:0]   temperature,
    output logic [tat_pkg::RES_W-1:0]           resistance,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [tat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tat_pkg::CFG_W-1:0]           cfg_data
);

    import tat_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = RES_W + TEMP_W;

    state_t state_reg, state_next;

    logic [EIU_W-1:0]    eiu_reg;
    logic [SERIES_W-1:0] series_reg;

    logic out_valid_reg;
    logic signed [TEMP_W-1:0] temperature_reg;
    logic [RES_W-1:0]         resistance_reg;
    status_t                  status_reg;

    logic [SAMPLE_W-1:0]      sample_reg;
    logic [RES_W-1:0]         r_reg;
    logic [PROD_W-1:0]        dvd_reg;
    logic [RES_W-1:0]         rem_reg;
    logic [RES_W-1:0]         dsr_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CW-1:0]            idx_reg;
    logic [RES_W-1:0]         prev_res_reg;
    logic signed [TEMP_W-1:0] prev_tmp_reg;
    logic [RES_W-1:0]         cur_res_reg;
    logic signed [TEMP_W-1:0] cur_tmp_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] t_reg;
    status_t                  st_reg;

    logic                     accept;
    logic                     out_free;
    logic                     div_busy;
    logic                     div_last;
    logic [CW-1:0]            n_eff;
    logic [CW-1:0]            idx_inc;
    logic [AW-1:0]            rd_addr;
    logic                     ram_we;
    logic [MW-1:0]            ram_rdata;
    logic [RES_W-1:0]         rd_res;
    logic signed [TEMP_W-1:0] rd_tmp;
    logic                     r_above;
    logic                     sample_zero;
    logic                     sample_full;

    logic [SERIES_W-1:0]      mul_a;
    logic [RES_W-1:0]         mul_b;
    logic [PROD_W-1:0]        mul_p;

    logic [RES_W:0]           trial;
    logic [RES_W:0]           diff;
    logic                     qbit;

    logic signed [TEMP_W:0]   dy;
    logic [TEMP_W-1:0]        abs_dy;
    logic [RES_W-1:0]         abs_off;
    logic [RES_W-1:0]         span;
    logic [TEMP_W-1:0]        quot;

    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign div_busy    = (state_reg == ST_DIV_R) || (state_reg == ST_DIV_T);
    assign div_last    = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign idx_inc     = idx_reg + 1'b1;
    assign rd_res      = ram_rdata[MW-1:TEMP_W];
    assign rd_tmp      = ram_rdata[TEMP_W-1:0];
    assign r_above     = r_reg > rd_res;
    assign sample_zero = (adc_sample == '0);
    assign sample_full = (int'(adc_sample) >= ADC_FULL_SCALE);
    assign ram_we      = accept && (req_type == REQ_LOAD) && (int'(entry_index) < TABLE_DEPTH);

    always_comb
    begin
        if (eiu_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (int'(eiu_reg) > TABLE_DEPTH)
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(eiu_reg);
        end
    end

    tat_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(entry_index)),
        .wdata ({entry_resistance, entry_temperature}),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // shared multiplier and restoring divider step
    assign mul_p = mul_a * mul_b;
    assign trial = {rem_reg, dvd_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    assign dy      = {cur_tmp_reg[TEMP_W-1], cur_tmp_reg} - {prev_tmp_reg[TEMP_W-1], prev_tmp_reg};
    assign abs_off = cur_res_reg - r_reg;
    assign span    = cur_res_reg - prev_res_reg;
    assign quot    = dvd_reg[TEMP_W-1:0];

    always_comb
    begin
        abs_dy = dy[TEMP_W] ? TEMP_W'(-dy) : TEMP_W'(dy);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (sample_zero || sample_full)
                    begin
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_MUL_R;
                    end
                end
            end
            ST_MUL_R: state_next = ST_DIV_R;
            ST_DIV_R:
            begin
                if (div_last)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = ST_SRCH;
            ST_SRCH:
            begin
                if (r_above)
                begin
                    if (idx_inc == n_eff)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T: state_next = ST_DIV_T;
            ST_DIV_T:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_addr  = '0;
        mul_a    = series_reg;
        mul_b    = RES_W'(sample_reg);
        unique case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_SRCH:  rd_addr  = idx_inc[AW-1:0];
            ST_MUL_T:
            begin
                mul_a = abs_dy;
                mul_b = abs_off;
            end
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            eiu_reg       <= EIU_RESET;
            series_reg    <= SERIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENTRIES: eiu_reg    <= cfg_data[EIU_W-1:0];
                    CFG_SERIES:  series_reg <= cfg_data[SERIES_W-1:0];
                    default:     eiu_reg    <= eiu_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= adc_sample;
                idx_reg    <= '0;
                if (req_type == REQ_LOAD)
                begin
                    t_reg  <= '0;
                    r_reg  <= '0;
                    st_reg <= STATUS_WRITTEN;
                end
                else if (sample_zero)
                begin
                    r_reg <= '0;
                end
                else
                begin
                    r_reg <= '1;
                end
            end
            ST_MUL_R, ST_MUL_T:
            begin
                dvd_reg <= mul_p;
                rem_reg <= '0;
                cnt_reg <= '0;
                dsr_reg <= (state_reg == ST_MUL_R) ?
                           RES_W'(ADC_FULL_SCALE - int'(sample_reg)) : span;
                neg_reg <= dy[TEMP_W];
            end
            ST_DIV_R, ST_DIV_T:
            begin
                rem_reg <= qbit ? diff[RES_W-1:0] : trial[RES_W-1:0];
                dvd_reg <= {dvd_reg[PROD_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last && state_reg == ST_DIV_R)
                begin
                    r_reg <= {dvd_reg[RES_W-2:0], qbit};
                end
                if (div_last && state_reg == ST_DIV_T)
                begin
                    t_reg  <= neg_reg ? cur_tmp_reg + $signed({quot[TEMP_W-2:0], qbit})
                                      : cur_tmp_reg - $signed({quot[TEMP_W-2:0], qbit});
                    st_reg <= STATUS_INTERP;
                end
            end
            ST_SRCH:
            begin
                idx_reg     <= idx_inc;
                cur_res_reg <= rd_res;
                cur_tmp_reg <= rd_tmp;
                t_reg       <= rd_tmp;
                if (r_above)
                begin
                    prev_res_reg <= rd_res;
                    prev_tmp_reg <= rd_tmp;
                    st_reg       <= STATUS_LAST;
                end
                else
                begin
                    st_reg <= STATUS_FIRST;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    temperature_reg <= t_reg;
                    resistance_reg  <= r_reg;
                    status_reg      <= st_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temperature_reg;
    assign resistance  = resistance_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted transfer did not start work");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> cnt_reg <= CNT_W'(DIV_STEPS - 1))
        else $error("divider step count overrun");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRCH |-> idx_reg < n_eff)
        else $error("search ran past entries in use");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_WRITTEN |->
            temperature_reg == '0 && resistance_reg == '0)
        else $error("load result carries data");
`endif

endmodule

// ===== design/tat_ram.sv =====
module tat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
